// File: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the vector unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/vapc_pkg.sv
// Package of the vector unit: formats, CORDIC angle table and shared types.
`timescale 1ns / 1ps

package vapc_pkg;

    // External data format.
    localparam int DATA_W       = 32;
    localparam int FRAC_BITS    = 16;

    // CORDIC set-up: guard bits on coordinates, fraction bits on angles.
    localparam int CORDIC_STEPS = 16;
    localparam int GUARD        = 8;
    localparam int ANG_FRAC     = 32;
    localparam int ATAN_LEN     = 24;

    // Internal widths: coordinates carry the gain and the root-two growth.
    localparam int XY_W         = 44;
    localparam int Z_W          = 42;

    // Half a turn in internal angle units.
    localparam logic signed [Z_W-1:0] DEG180 = Z_W'(longint'(180) <<< ANG_FRAC);

    // atan(2^-i) in degrees with ANG_FRAC fraction bits.
    localparam logic signed [Z_W-1:0] ATAN_DEG [ATAN_LEN] = '{
        42'sd193273528320, 42'sd114096026022, 42'sd60285206653, 42'sd30601712202,
        42'sd15360239160,  42'sd7687607525,   42'sd3844741810,  42'sd1922488226,
        42'sd961258779,    42'sd480631223,    42'sd240315841,   42'sd120157949,
        42'sd60078978,     42'sd30039490,     42'sd15019745,    42'sd7509872,
        42'sd3754936,      42'sd1877468,      42'sd938734,      42'sd469367,
        42'sd234684,       42'sd117342,       42'sd58671,       42'sd29335
    };

    // Opcodes of an input item.
    typedef enum logic [1:0] {
        OP_P2C       = 2'd0,
        OP_C2P       = 2'd1,
        OP_ADD_CART  = 2'd2,
        OP_ADD_POLAR = 2'd3
    } t_opcode;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_BASE_X = 1'b0,
        CFG_BASE_Y = 1'b1
    } t_cfg_reg;

    // What the CORDIC stages do with an item.
    typedef enum logic [1:0] {
        MODE_ROT  = 2'd0,
        MODE_VEC  = 2'd1,
        MODE_PASS = 2'd2
    } t_mode;

    // One item as it travels through the CORDIC stages.
    typedef struct packed {
        logic                   valid;
        t_mode                  mode;
        logic                   zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

endpackage

// File: rtl/core/vapc_cordic.sv
// Unrolled CORDIC pipeline: an input register and one register stage per iteration.
`timescale 1ns / 1ps

module vapc_cordic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  vapc_pkg::t_cordic i_st,
    output vapc_pkg::t_cordic o_st
);
    import vapc_pkg::*;

    t_cordic r_st [CORDIC_STEPS+1];
    t_cordic n_st [CORDIC_STEPS+1];

    // The first register takes the prepared item as it is.
    assign n_st[0] = i_st;

    for (genvar k = 0; k <= CORDIC_STEPS; k++) begin : g_reg
        // Stage register; the whole pipeline holds while the output is stalled.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].valid <= 1'b0;
            end else if (i_en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
        logic signed [XY_W-1:0] w_dx;
        logic signed [XY_W-1:0] w_dy;

        // Shifts by the iteration number are plain wiring.
        assign w_dx = r_st[k].y >>> k;
        assign w_dy = r_st[k].x >>> k;

        // One micro-rotation, steered by the angle residue or by the sign of y.
        always_comb begin
            n_st[k+1] = r_st[k];
            case (r_st[k].mode)
                MODE_ROT: begin
                    if (!r_st[k].z[Z_W-1]) begin
                        n_st[k+1].x = r_st[k].x - w_dx;
                        n_st[k+1].y = r_st[k].y + w_dy;
                        n_st[k+1].z = r_st[k].z - ATAN_DEG[k];
                    end else begin
                        n_st[k+1].x = r_st[k].x + w_dx;
                        n_st[k+1].y = r_st[k].y - w_dy;
                        n_st[k+1].z = r_st[k].z + ATAN_DEG[k];
                    end
                end
                MODE_VEC: begin
                    if (!r_st[k].y[XY_W-1]) begin
                        n_st[k+1].x = r_st[k].x + w_dx;
                        n_st[k+1].y = r_st[k].y - w_dy;
                        n_st[k+1].z = r_st[k].z + ATAN_DEG[k];
                    end else begin
                        n_st[k+1].x = r_st[k].x - w_dx;
                        n_st[k+1].y = r_st[k].y + w_dy;
                        n_st[k+1].z = r_st[k].z - ATAN_DEG[k];
                    end
                end
                default: begin
                    // Sums pass through untouched.
                end
            endcase
        end
    end

    assign o_st = r_st[CORDIC_STEPS];

endmodule

// File: rtl/core/vector_add_polar_cartesian_unit.sv
// Top level of the two-dimensional vector unit (polar/cartesian conversion and add).
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Vector unit in signed Q16.16 with angles in degrees. One item is taken per
// clock cycle while the output is not stalled; its result passes three
// front-end stages (base add, gain and modulo-360 multipliers, rounding and
// remainder), 17 CORDIC registers (set-up plus one per iteration) and the
// output register with rounding and saturation. The pipeline advances as a
// whole whenever the output register is empty or its result is being taken,
// so a stalled output holds every stage and input ready drops with it. The
// base vector registers are written through the configuration port and reset
// to zero. The overflow flag marks a saturated coordinate, magnitude or sum.
module vector_add_polar_cartesian_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_opcode,
    input  logic signed [vapc_pkg::DATA_W-1:0]   i_in_a,
    input  logic signed [vapc_pkg::DATA_W-1:0]   i_in_b,
    // Output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [vapc_pkg::DATA_W-1:0]   o_out_a,
    output logic signed [vapc_pkg::DATA_W-1:0]   o_out_b,
    output logic                                 o_overflow,
    // Configuration port
    input  logic                                 i_cfg_we,
    input  logic [0:0]                           i_cfg_index,
    input  logic [vapc_pkg::DATA_W-1:0]          i_cfg_wdata
);
    import vapc_pkg::*;

    // Widths and constants of the front end.
    localparam int SUM_W   = DATA_W + 1;
    localparam int GAIN_W  = 31;
    localparam int PROD_W  = SUM_W + GAIN_W;
    localparam int PS_SH   = 30 - GUARD;
    localparam int INT_W   = DATA_W - FRAC_BITS;
    localparam int U_W     = INT_W + 1;
    localparam int Q_W     = U_W - 8;
    localparam int R_W     = 9;
    localparam int RCP_SH  = U_W + 9;
    localparam int RCP_W   = RCP_SH - 8;
    localparam int ANG_OFS = 360 * ((2 ** (INT_W - 1) + 359) / 360);
    localparam int ZQ_W    = R_W + 1 + FRAC_BITS;

    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;
    localparam logic signed [PROD_W-1:0] PS_HALF  = PROD_W'(longint'(1) <<< (PS_SH - 1));
    localparam logic [RCP_W-1:0] RECIP    = RCP_W'(((longint'(1) << RCP_SH) + 359) / 360);
    localparam logic [U_W-1:0]   U_OFS    = U_W'(ANG_OFS);
    localparam logic [U_W-1:0]   U_360    = U_W'(360);
    localparam logic [R_W-1:0]   R_180    = R_W'(180);
    localparam logic signed [R_W:0] S_360 = (R_W+1)'(360);
    localparam logic signed [R_W:0] S_180 = (R_W+1)'(180);
    localparam logic signed [R_W:0] S_90  = (R_W+1)'(90);

    localparam logic signed [XY_W-1:0] XY_RND  = XY_W'(longint'(1) <<< (GUARD - 1));
    localparam logic signed [Z_W-1:0]  Z_RND   =
        Z_W'(longint'(1) <<< (ANG_FRAC - FRAC_BITS - 1));
    localparam logic signed [Z_W-1:0]  DEG180_OUT = Z_W'(longint'(180) <<< FRAC_BITS);
    localparam logic signed [XY_W-1:0] SAT_HI  =
        XY_W'((longint'(1) <<< (DATA_W - 1)) - 1);
    localparam logic signed [XY_W-1:0] SAT_LO  = XY_W'(-(longint'(1) <<< (DATA_W - 1)));
    localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Saturate a wide value to the output width; the top bit is the overflow.
    function automatic logic [DATA_W:0] sat_out(input logic signed [XY_W-1:0] v);
        logic [DATA_W:0] res;
        if (v > SAT_HI) begin
            res = {1'b1, OUT_MAX};
        end else if (v < SAT_LO) begin
            res = {1'b1, OUT_MIN};
        end else begin
            res = {1'b0, v[DATA_W-1:0]};
        end
        return res;
    endfunction

    // Whole-pipeline advance: the output register is free or being emptied.
    logic r_out_valid;
    logic w_adv;
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // ---------------------------------------------------------------------
    // Base vector registers.
    // ---------------------------------------------------------------------
    logic signed [DATA_W-1:0] r_base_x;
    logic signed [DATA_W-1:0] r_base_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x <= '0;
            r_base_y <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_BASE_X: r_base_x <= i_cfg_wdata;
                CFG_BASE_Y: r_base_y <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: base add, job selection and offset of the angle's integer part.
    // ---------------------------------------------------------------------
    t_opcode                 w_op;
    logic signed [SUM_W-1:0] w_sum_a;
    logic signed [SUM_W-1:0] w_sum_b;
    logic                    w_is_add;
    t_mode                   n1_mode;
    logic signed [SUM_W-1:0] n1_x0;
    logic signed [SUM_W-1:0] n1_y0;
    logic [U_W-1:0]          n1_u;

    assign w_op     = t_opcode'(i_opcode);
    assign w_sum_a  = {i_in_a[DATA_W-1], i_in_a} + {r_base_x[DATA_W-1], r_base_x};
    assign w_sum_b  = {i_in_b[DATA_W-1], i_in_b} + {r_base_y[DATA_W-1], r_base_y};
    assign w_is_add = (w_op == OP_ADD_CART) || (w_op == OP_ADD_POLAR);
    assign n1_x0    = w_is_add ? w_sum_a : {i_in_a[DATA_W-1], i_in_a};
    assign n1_y0    = w_is_add ? w_sum_b : {i_in_b[DATA_W-1], i_in_b};
    // A multiple of 360 lifts the signed integer part into a positive range.
    assign n1_u     = {i_in_b[DATA_W-1], i_in_b[DATA_W-1:FRAC_BITS]} + U_OFS;

    always_comb begin
        case (w_op)
            OP_P2C:      n1_mode = MODE_ROT;
            OP_ADD_CART: n1_mode = MODE_PASS;
            default:     n1_mode = MODE_VEC;
        endcase
    end

    logic                    r1_valid;
    t_mode                   r1_mode;
    logic signed [SUM_W-1:0] r1_x0;
    logic signed [SUM_W-1:0] r1_y0;
    logic [U_W-1:0]          r1_u;
    logic [FRAC_BITS-1:0]    r1_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mode <= n1_mode;
            r1_x0   <= n1_x0;
            r1_y0   <= n1_y0;
            r1_u    <= n1_u;
            r1_frac <= i_in_b[FRAC_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: gain compensation products and quotient by 360.
    // ---------------------------------------------------------------------
    logic signed [PROD_W-1:0]  n2_px;
    logic signed [PROD_W-1:0]  n2_py;
    logic [U_W+RCP_W-1:0]      w2_qp;

    assign n2_px = r1_x0 * GAIN_Q30;
    assign n2_py = r1_y0 * GAIN_Q30;
    // The rounded-up reciprocal is exact for every offset angle value.
    assign w2_qp = r1_u * RECIP;

    logic                    r2_valid;
    t_mode                   r2_mode;
    logic signed [PROD_W-1:0] r2_px;
    logic signed [PROD_W-1:0] r2_py;
    logic signed [SUM_W-1:0] r2_x0;
    logic signed [SUM_W-1:0] r2_y0;
    logic [Q_W-1:0]          r2_q;
    logic [U_W-1:0]          r2_u;
    logic [FRAC_BITS-1:0]    r2_frac;
    logic                    r2_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_mode <= r1_mode;
            r2_px   <= n2_px;
            r2_py   <= n2_py;
            r2_x0   <= r1_x0;
            r2_y0   <= r1_y0;
            r2_q    <= w2_qp[RCP_SH +: Q_W];
            r2_u    <= r1_u;
            r2_frac <= r1_frac;
            r2_zero <= (r1_x0 == '0) && (r1_y0 == '0);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: round the scaled coordinates, integer degrees modulo 360.
    // ---------------------------------------------------------------------
    logic signed [PROD_W-1:0] w3_px;
    logic signed [PROD_W-1:0] w3_py;
    logic [U_W-1:0]           w3_qm;
    logic [U_W-1:0]           w3_r;

    assign w3_px = (r2_px + PS_HALF) >>> PS_SH;
    assign w3_py = (r2_py + PS_HALF) >>> PS_SH;
    assign w3_qm = U_W'(r2_q) * U_360;
    assign w3_r  = r2_u - w3_qm;

    logic                    r3_valid;
    t_mode                   r3_mode;
    logic signed [XY_W-1:0]  r3_x;
    logic signed [XY_W-1:0]  r3_y;
    logic signed [SUM_W-1:0] r3_x0;
    logic signed [SUM_W-1:0] r3_y0;
    logic [R_W-1:0]          r3_r;
    logic [FRAC_BITS-1:0]    r3_frac;
    logic                    r3_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_mode <= r2_mode;
            r3_x    <= w3_px[XY_W-1:0];
            r3_y    <= w3_py[XY_W-1:0];
            r3_x0   <= r2_x0;
            r3_y0   <= r2_y0;
            r3_r    <= w3_r[R_W-1:0];
            r3_frac <= r2_frac;
            r3_zero <= r2_zero;
        end
    end

    // ---------------------------------------------------------------------
    // CORDIC set-up: fold the angle into [-90, 90], move x to the right half or pass sums.
    // ---------------------------------------------------------------------
    logic signed [R_W:0]    w4_rs;
    logic                   w4_hi;
    logic                   w4_lo;
    logic signed [R_W:0]    w4_rf;
    logic signed [ZQ_W-1:0] w4_z16;
    logic signed [Z_W-1:0]  w4_zq;
    logic                   w4_xneg;
    t_cordic                w4_st;

    assign w4_rs   = (r3_r >= R_180) ? $signed({1'b0, r3_r}) - S_360
                                     : $signed({1'b0, r3_r});
    assign w4_hi   = (w4_rs > S_90) || ((w4_rs == S_90) && (r3_frac != '0));
    assign w4_lo   = (w4_rs < -S_90);
    assign w4_rf   = w4_hi ? (w4_rs - S_180) : (w4_lo ? (w4_rs + S_180) : w4_rs);
    assign w4_z16  = {w4_rf, r3_frac};
    assign w4_zq   = Z_W'(w4_z16);
    assign w4_xneg = r3_x0[SUM_W-1];

    always_comb begin
        w4_st.valid = r3_valid;
        w4_st.mode  = r3_mode;
        w4_st.zero  = r3_zero;
        case (r3_mode)
            MODE_ROT: begin
                w4_st.x = (w4_hi || w4_lo) ? -r3_x : r3_x;
                w4_st.y = '0;
                w4_st.z = w4_zq <<< (ANG_FRAC - FRAC_BITS);
            end
            MODE_VEC: begin
                // Negative x: start from the opposite vector and a half turn.
                w4_st.x = w4_xneg ? -r3_x : r3_x;
                w4_st.y = w4_xneg ? -r3_y : r3_y;
                if (!w4_xneg) begin
                    w4_st.z = '0;
                end else if (!r3_y0[SUM_W-1]) begin
                    w4_st.z = DEG180;
                end else begin
                    w4_st.z = -DEG180;
                end
            end
            default: begin
                w4_st.x = XY_W'(r3_x0);
                w4_st.y = XY_W'(r3_y0);
                w4_st.z = '0;
            end
        endcase
    end

    t_cordic w_cd;

    vapc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_st    (w4_st),
        .o_st    (w_cd)
    );

    // ---------------------------------------------------------------------
    // Result: round off guard bits, clamp the angle, saturate.
    // ---------------------------------------------------------------------
    logic signed [XY_W-1:0] w_rx;
    logic signed [XY_W-1:0] w_ry;
    logic signed [Z_W-1:0]  w_rz;
    logic signed [Z_W-1:0]  w_rzc;
    logic signed [XY_W-1:0] w_fa;
    logic signed [XY_W-1:0] w_fb;
    logic [DATA_W:0]        w_sa;
    logic [DATA_W:0]        w_sb;

    assign w_rx = (w_cd.x + XY_RND) >>> GUARD;
    assign w_ry = (w_cd.y + XY_RND) >>> GUARD;
    assign w_rz = (w_cd.z + Z_RND) >>> (ANG_FRAC - FRAC_BITS);

    // Clamping after rounding matches clamping before, as a half turn rounds exactly.
    always_comb begin
        if (w_rz > DEG180_OUT) begin
            w_rzc = DEG180_OUT;
        end else if (w_rz < -DEG180_OUT) begin
            w_rzc = -DEG180_OUT;
        end else begin
            w_rzc = w_rz;
        end
    end

    always_comb begin
        case (w_cd.mode)
            MODE_ROT: begin
                w_fa = w_rx;
                w_fb = w_ry;
            end
            MODE_VEC: begin
                // The zero vector reads as magnitude zero at angle zero.
                w_fa = w_cd.zero ? '0 : w_rx;
                w_fb = w_cd.zero ? '0 : XY_W'(w_rzc);
            end
            default: begin
                w_fa = w_cd.x;
                w_fb = w_cd.y;
            end
        endcase
    end

    assign w_sa = sat_out(w_fa);
    assign w_sb = sat_out(w_fb);

    logic signed [DATA_W-1:0] r_out_a;
    logic signed [DATA_W-1:0] r_out_b;
    logic                     r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_cd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_a   <= w_sa[DATA_W-1:0];
            r_out_b   <= w_sb[DATA_W-1:0];
            r_out_ovf <= w_sa[DATA_W] || w_sb[DATA_W];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_a     = r_out_a;
    assign o_out_b     = r_out_b;
    assign o_overflow  = r_out_ovf;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    `ASSERT_IMPLY(a_ovf_at_limit, i_clk, i_rst_n, o_out_valid && o_overflow, (o_out_a == OUT_MAX || o_out_a == OUT_MIN || o_out_b == OUT_MAX || o_out_b == OUT_MIN), "overflow flagged without a saturated field")
    `ASSERT_NEXT(a_cordic_holds, i_clk, i_rst_n, !w_adv, $stable(w_cd), "CORDIC pipeline moved while the output was stalled")
    `ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_overflow), "stalled result changed")

endmodule
